FILE: hdl/fsa_pkg.sv
package fsa_pkg;

    localparam int SLOT_BITS = 10;
    localparam int COUNT_BITS = 11;
    localparam int TOTAL_BITS = 32;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_GRANT  = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FREED  = 2'd2,
        ST_REJECT = 2'd3
    } t_fsa_status;

    typedef struct packed {
        logic                 func;
        logic [SLOT_BITS-1:0] slot_in;
    } t_fsa_req;

    typedef struct packed {
        t_fsa_status           status;
        logic [SLOT_BITS-1:0]  slot_out;
        logic [COUNT_BITS-1:0] free_slots;
        logic [COUNT_BITS-1:0] peak_usage;
        logic [TOTAL_BITS-1:0] alloc_total;
        logic [TOTAL_BITS-1:0] hit_total;
        logic [TOTAL_BITS-1:0] miss_total;
        logic [TOTAL_BITS-1:0] release_total;
    } t_fsa_res;

    typedef struct packed {
        logic fire;
        logic alloc;
        logic hit;
        logic rel;
    } t_fsa_evt;

    typedef struct packed {
        logic [TOTAL_BITS-1:0] alloc_total;
        logic [TOTAL_BITS-1:0] hit_total;
        logic [TOTAL_BITS-1:0] miss_total;
        logic [TOTAL_BITS-1:0] release_total;
    } t_fsa_cnt;

endpackage

FILE: hdl/fsa_ram.sv
module fsa_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // read returns the old word on a same-cycle write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_q;

endmodule

FILE: hdl/fsa_stats.sv
module fsa_stats #(
    parameter int TOP_W = 11
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fsa_pkg::t_fsa_evt   i_evt,
    input  logic [TOP_W-1:0]    i_usage,
    output fsa_pkg::t_fsa_cnt   o_cnt_next,
    output logic [TOP_W-1:0]    o_peak_next
);

    import fsa_pkg::*;

    t_fsa_cnt         r_cnt;
    t_fsa_cnt         n_cnt;
    logic [TOP_W-1:0] r_peak;
    logic [TOP_W-1:0] n_peak;

    always_comb begin
        n_cnt  = r_cnt;
        n_peak = r_peak;
        if (i_evt.fire) begin
            if (i_evt.alloc) begin
                n_cnt.alloc_total = r_cnt.alloc_total + 1'b1;
                if (i_evt.hit) begin
                    n_cnt.hit_total = r_cnt.hit_total + 1'b1;
                    if (i_usage > r_peak) begin
                        n_peak = i_usage;
                    end
                end else begin
                    n_cnt.miss_total = r_cnt.miss_total + 1'b1;
                end
            end else if (i_evt.rel) begin
                n_cnt.release_total = r_cnt.release_total + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_peak <= '0;
        end else begin
            r_cnt  <= n_cnt;
            r_peak <= n_peak;
        end
    end

    assign o_cnt_next  = n_cnt;
    assign o_peak_next = n_peak;

endmodule

FILE: hdl/free_list_slot_allocator_unit.sv
// Slot allocator over a pool of POOL_DEPTH slots, LIFO free list plus busy bits.
// Request channel: i_valid / o_stall carrying i_req (func, slot_in).
//   func alloc pops a free slot; func free returns a busy slot to the list.
// Result channel: o_valid / i_stall carrying o_res, one result beat per request.
// Throughput: one request per cycle outside the clearing pass and receiver stalls,
//   set by the single read and write port of the free-list RAM and of the busy-bit
//   RAM; back-to-back hazards are bypassed. An accepted request passes the RAM read
//   stage, then the decision stage into the result register.
// Reset: counters and peak clear and the stack pointer returns to full at once; the
//   free list needs no init (entries below the lowest stack level ever reached read
//   as their own index). The busy-bit RAM is cleared by a pass over all POOL_DEPTH
//   entries after reset, during which o_stall is held high.
// Receiver stall: the result register holds; the request in the read stage waits,
//   and one more request can still be taken while the result register is full
//   and the read stage is empty.
module free_list_slot_allocator_unit #(
    parameter int POOL_DEPTH = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  fsa_pkg::t_fsa_req i_req,
    output logic              o_valid,
    input  logic              i_stall,
    output fsa_pkg::t_fsa_res o_res
);

    import fsa_pkg::*;

    localparam int SLOT_W = $clog2(POOL_DEPTH);
    localparam int TOP_W  = $clog2(POOL_DEPTH + 1);
    localparam logic [TOP_W-1:0]  DEPTH_T = TOP_W'(POOL_DEPTH);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(POOL_DEPTH - 1);

    // clearing pass
    logic              r_clr_act;
    logic [SLOT_W-1:0] r_clr_addr;

    // architectural state
    logic [TOP_W-1:0] r_top;
    logic [TOP_W-1:0] r_min_top;
    logic [TOP_W-1:0] n_top;
    logic [TOP_W-1:0] n_min;

    // read stage
    logic                 r_s1_v;
    logic                 r_s1_func;
    logic [SLOT_BITS-1:0] r_s1_slot;
    logic                 r_s1_init;
    logic                 r_s1_bb;
    logic                 r_s1_bbv;
    logic                 r_s1_sb;
    logic [SLOT_W-1:0]    r_s1_sbd;

    // result register
    logic     r_out_v;
    t_fsa_res r_out;

    logic              acc;
    logic              s1_adv;
    logic              s1_fire;
    logic              s1_alloc;
    logic              s1_hit;
    logic              s1_rel;
    logic              s1_slot_ok;
    logic              s1_busy;
    logic [SLOT_W-1:0] s1_pos;
    logic [SLOT_W-1:0] s1_pop;
    logic [0:0]        busy_rd;
    logic [SLOT_W-1:0] stack_q;

    logic              busy_we;
    logic [SLOT_W-1:0] busy_waddr;
    logic              busy_wdata;
    logic              stack_we;

    t_fsa_evt         evt;
    t_fsa_cnt         cnt_next;
    logic [TOP_W-1:0] peak_next;
    logic [TOP_W-1:0] usage;
    t_fsa_res         res;

    assign s1_adv  = !r_out_v || !i_stall;
    assign o_stall = r_clr_act || (r_s1_v && !s1_adv);
    assign acc     = i_valid && !o_stall;
    assign s1_fire = r_s1_v && s1_adv;

    assign s1_busy    = r_s1_bb ? r_s1_bbv : busy_rd[0];
    assign s1_pos     = SLOT_W'(r_top - 1'b1);
    assign s1_pop     = r_s1_sb ? r_s1_sbd : (r_s1_init ? s1_pos : stack_q);
    assign s1_slot_ok = 32'(r_s1_slot) < 32'(POOL_DEPTH);
    assign s1_alloc   = r_s1_func == FUNC_ALLOC;
    assign s1_hit     = s1_alloc && (r_top != '0);
    assign s1_rel     = !s1_alloc && s1_slot_ok && s1_busy && (r_top < DEPTH_T);

    always_comb begin
        n_top = r_top;
        if (s1_fire && s1_hit) begin
            n_top = r_top - 1'b1;
        end else if (s1_fire && s1_rel) begin
            n_top = r_top + 1'b1;
        end
        n_min = (n_top < r_min_top) ? n_top : r_min_top;
    end

    always_comb begin
        busy_we    = 1'b0;
        busy_waddr = r_clr_addr;
        busy_wdata = 1'b0;
        if (r_clr_act) begin
            busy_we = 1'b1;
        end else if (s1_fire && s1_hit) begin
            busy_we    = 1'b1;
            busy_waddr = s1_pop;
            busy_wdata = 1'b1;
        end else if (s1_fire && s1_rel) begin
            busy_we    = 1'b1;
            busy_waddr = SLOT_W'(r_s1_slot);
        end
    end

    assign stack_we = s1_fire && s1_rel;

    fsa_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (POOL_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stack_we),
        .i_waddr (SLOT_W'(r_top)),
        .i_wdata (SLOT_W'(r_s1_slot)),
        .i_re    (acc),
        .i_raddr (SLOT_W'(n_top - 1'b1)),
        .o_rdata (stack_q)
    );

    fsa_ram #(
        .WIDTH (1),
        .DEPTH (POOL_DEPTH)
    ) u_busy_ram (
        .i_clk   (i_clk),
        .i_we    (busy_we),
        .i_waddr (busy_waddr),
        .i_wdata (busy_wdata),
        .i_re    (acc),
        .i_raddr (SLOT_W'(i_req.slot_in)),
        .o_rdata (busy_rd)
    );

    assign evt.fire  = s1_fire;
    assign evt.alloc = s1_alloc;
    assign evt.hit   = s1_hit;
    assign evt.rel   = s1_rel;
    assign usage     = DEPTH_T - n_top;

    fsa_stats #(
        .TOP_W (TOP_W)
    ) u_stats (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt       (evt),
        .i_usage     (usage),
        .o_cnt_next  (cnt_next),
        .o_peak_next (peak_next)
    );

    always_comb begin
        res               = '0;
        res.free_slots    = COUNT_BITS'(n_top);
        res.peak_usage    = COUNT_BITS'(peak_next);
        res.alloc_total   = cnt_next.alloc_total;
        res.hit_total     = cnt_next.hit_total;
        res.miss_total    = cnt_next.miss_total;
        res.release_total = cnt_next.release_total;
        if (s1_alloc) begin
            if (s1_hit) begin
                res.status   = ST_GRANT;
                res.slot_out = SLOT_BITS'(s1_pop);
            end else begin
                res.status = ST_EMPTY;
            end
        end else begin
            res.status = s1_rel ? ST_FREED : ST_REJECT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_act  <= 1'b1;
            r_clr_addr <= '0;
            r_top      <= DEPTH_T;
            r_min_top  <= DEPTH_T;
            r_s1_v     <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            if (r_clr_act) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_SLOT) begin
                    r_clr_act <= 1'b0;
                end
            end
            r_top     <= n_top;
            r_min_top <= n_min;
            if (acc) begin
                r_s1_v <= 1'b1;
            end else if (s1_fire) begin
                r_s1_v <= 1'b0;
            end
            if (s1_adv) begin
                r_out_v <= r_s1_v;
            end
        end
    end

    // payload: bypass of the write committed in the same cycle as the read
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_func <= i_req.func;
            r_s1_slot <= i_req.slot_in;
            r_s1_init <= n_top <= n_min;
            r_s1_bb   <= busy_we && (busy_waddr == SLOT_W'(i_req.slot_in));
            r_s1_bbv  <= busy_wdata;
            r_s1_sb   <= stack_we;
            r_s1_sbd  <= SLOT_W'(r_s1_slot);
        end
        if (s1_fire) begin
            r_out <= res;
        end
    end

    assign o_valid = r_out_v;
    assign o_res   = r_out;

    a_clr_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_act |-> o_stall)
        else $error("request taken during busy-bit clear");

    a_pop_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && s1_hit) |=> (r_top == $past(r_top) - 1'b1))
        else $error("stack pointer did not step on grant");

    a_min_top : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_min_top <= r_top) && (r_top <= DEPTH_T))
        else $error("stack level bookkeeping out of range");

    a_grant_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_res.status == ST_GRANT)) |->
            (32'(o_res.slot_out) < 32'(POOL_DEPTH)))
        else $error("granted slot outside pool");

endmodule

FILE: tb/sv/free_list_slot_allocator_unit_tb.sv
module free_list_slot_allocator_unit_tb;
    import fsa_pkg::*;

    localparam int POOL = 1024;
    localparam int HOLD_CYCLES = 200;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 1900;
    localparam int MISS_TARGET = 16;
    localparam int DRAIN_LEVEL = 640;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_stall;
    t_fsa_req i_req;
    logic     o_valid;
    logic     i_stall;
    t_fsa_res o_res;

    free_list_slot_allocator_unit #(
        .POOL_DEPTH(POOL)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (o_res)
    );

    // shadow of the pool
    logic [SLOT_BITS-1:0]  pool_stack [POOL];
    bit                    pool_busy [POOL];
    int                    pool_top;
    int                    pool_peak;
    logic [TOTAL_BITS-1:0] alloc_cnt;
    logic [TOTAL_BITS-1:0] hit_cnt;
    logic [TOTAL_BITS-1:0] miss_cnt;
    logic [TOTAL_BITS-1:0] rel_cnt;

    t_fsa_res pending_res [$];
    int       mismatches = 0;
    int       items_sent = 0;
    int       cycle_cnt = 0;
    bit       send_steady = 1'b0;
    bit       recv_steady = 1'b0;
    bit       hold_req = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void pool_reset();
        for (int k = 0; k < POOL; k++) begin
            pool_stack[k] = SLOT_BITS'(k);
            pool_busy[k] = 1'b0;
        end
        pool_top = POOL;
        pool_peak = 0;
        alloc_cnt = '0;
        hit_cnt = '0;
        miss_cnt = '0;
        rel_cnt = '0;
    endfunction

    function automatic t_fsa_res pool_step(input t_fsa_req req);
        t_fsa_res res;
        res = '0;
        if (req.func == FUNC_ALLOC) begin
            alloc_cnt = alloc_cnt + 1;
            if (pool_top > 0) begin
                pool_top = pool_top - 1;
                res.slot_out = pool_stack[pool_top];
                pool_busy[res.slot_out] = 1'b1;
                hit_cnt = hit_cnt + 1;
                if (POOL - pool_top > pool_peak) begin
                    pool_peak = POOL - pool_top;
                end
                res.status = ST_GRANT;
            end else begin
                miss_cnt = miss_cnt + 1;
                res.status = ST_EMPTY;
            end
        end else if (pool_busy[req.slot_in] && pool_top < POOL) begin
            pool_busy[req.slot_in] = 1'b0;
            pool_stack[pool_top] = req.slot_in;
            pool_top = pool_top + 1;
            rel_cnt = rel_cnt + 1;
            res.status = ST_FREED;
        end else begin
            res.status = ST_REJECT;
        end
        res.free_slots = COUNT_BITS'(pool_top);
        res.peak_usage = COUNT_BITS'(pool_peak);
        res.alloc_total = alloc_cnt;
        res.hit_total = hit_cnt;
        res.miss_total = miss_cnt;
        res.release_total = rel_cnt;
        return res;
    endfunction

    function automatic logic [SLOT_BITS-1:0] pick_busy();
        int start;
        start = $urandom_range(0, POOL - 1);
        for (int k = 0; k < POOL; k++) begin
            if (pool_busy[(start + k) % POOL]) begin
                return SLOT_BITS'((start + k) % POOL);
            end
        end
        return SLOT_BITS'(start);
    endfunction

    task automatic send_req(input logic func, input logic [SLOT_BITS-1:0] slot,
                            input bit no_gap);
        int       gap;
        t_fsa_req req;
        req.func = func;
        req.slot_in = slot;
        if ($urandom_range(0, 49) == 0) begin
            send_steady = !send_steady;
        end
        gap = (no_gap || send_steady) ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (o_stall);
        pending_res.push_back(pool_step(req));
        items_sent++;
    endtask

    // alloc_pct / free_pct of beats; the rest frees a random slot
    task automatic send_mix(input int alloc_pct, input int free_pct, input bit no_gap);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < alloc_pct) begin
            send_req(FUNC_ALLOC, SLOT_BITS'($urandom), no_gap);
        end else if (pick < alloc_pct + free_pct) begin
            send_req(FUNC_FREE, pick_busy(), no_gap);
        end else begin
            send_req(FUNC_FREE, SLOT_BITS'($urandom), no_gap);
        end
    endtask

    task automatic test_reset_state();
        send_req(FUNC_FREE, '0, 1'b0);
        send_req(FUNC_FREE, '1, 1'b0);
        send_req(FUNC_ALLOC, '0, 1'b0);
        send_req(FUNC_ALLOC, '0, 1'b0);
        send_req(FUNC_FREE, '1, 1'b0);
        send_req(FUNC_ALLOC, '0, 1'b0);
        send_req(FUNC_FREE, SLOT_BITS'(POOL - 2), 1'b0);
        send_req(FUNC_FREE, SLOT_BITS'(POOL - 2), 1'b0);
        send_req(FUNC_ALLOC, '1, 1'b0);
    endtask

    task automatic test_lifo_order();
        repeat (3) send_req(FUNC_ALLOC, '0, 1'b1);
        send_req(FUNC_FREE, SLOT_BITS'(POOL - 4), 1'b1);
        send_req(FUNC_FREE, SLOT_BITS'(POOL - 5), 1'b1);
        send_req(FUNC_FREE, SLOT_BITS'(POOL - 3), 1'b1);
        repeat (3) send_req(FUNC_ALLOC, '0, 1'b0);
        send_req(FUNC_FREE, SLOT_BITS'(1), 1'b0);
    endtask

    // receiver holds off while requests keep coming
    task automatic test_backpressure();
        hold_req = 1'b1;
        repeat (40) send_mix(60, 35, 1'b1);
    endtask

    task automatic test_exhaust();
        while (miss_cnt < MISS_TARGET) send_mix(92, 5, 1'b0);
    endtask

    task automatic test_drain();
        while (pool_top < DRAIN_LEVEL) send_mix(5, 90, 1'b0);
    endtask

    task automatic test_mixed();
        while (items_sent < ITEM_TARGET) send_mix(50, 40, 1'b0);
    endtask

    initial begin
        pool_reset();
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_req <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_lifo_order();
        test_backpressure();
        test_exhaust();
        test_drain();
        test_mixed();
        i_valid <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("free_list_slot_allocator_unit verification clean");
        end else begin
            $display("free_list_slot_allocator_unit verification failed");
        end
        $finish;
    end

    initial begin
        int n;
        i_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 49) == 0) begin
                recv_steady = !recv_steady;
            end
            if (hold_req) begin
                hold_req = 1'b0;
                n = HOLD_CYCLES;
            end else begin
                n = recv_steady ? 0 : $urandom_range(0, 8);
            end
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_valid);
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_fsa_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_res.size() == 0) begin
                mismatches++;
                $display("%0t: result beat expected none got %h", $time, o_res);
            end else begin
                want = pending_res.pop_front();
                check_field("status", want.status, o_res.status);
                check_field("slot_out", want.slot_out, o_res.slot_out);
                check_field("free_slots", want.free_slots, o_res.free_slots);
                check_field("peak_usage", want.peak_usage, o_res.peak_usage);
                check_field("alloc_total", want.alloc_total, o_res.alloc_total);
                check_field("hit_total", want.hit_total, o_res.hit_total);
                check_field("miss_total", want.miss_total, o_res.miss_total);
                check_field("release_total", want.release_total, o_res.release_total);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("free_list_slot_allocator_unit verification failed");
            $finish;
        end
    end

endmodule
